@@ hw/rtl/perspective_world_to_screen_core_macros.svh @@
// Assertion macros used by pwsc_queue.
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_CORE_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PWSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PWSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared constants and codes of the world-to-screen projection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwsc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 14;
    localparam int IDX_W         = 4;
    localparam int N_ENTRY       = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUOT_W        = 33;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    localparam logic REG_WIDTH   = 1'b0;
    localparam logic REG_HEIGHT  = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;
endpackage

@@ hw/rtl/pwsc_front.sv @@
// ----------------------------------------------------------------------------
// pwsc_front
// Accepts items, keeps the view matrix, and computes clip x, y, w.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwsc_front #(
    parameter int FRAC_BITS = pwsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic                                i_req_type,
    input  logic [pwsc_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_entry_value,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_x,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_y,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_z,
    output logic                                o_valid,
    output logic signed [66-FRAC_BITS-1:0]      o_cx,
    output logic signed [66-FRAC_BITS-1:0]      o_cy,
    output logic signed [66-FRAC_BITS-1:0]      o_cw,
    output logic [1:0]                          o_busy
);
    import pwsc_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;
    localparam int PROD_W = 64 - FRAC_BITS;

    logic [DATA_W-1:0]        r_matrix [N_ENTRY];
    logic signed [DATA_W-1:0] w_pt [3];
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [DATA_W-1:0] r_trans [3];
    logic signed [CLIP_W-1:0] r_clip [3];

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ENTRY; k++) begin
                r_matrix[k] <= '0;
            end
        end else if (i_take && i_req_type == REQ_WRITE) begin
            r_matrix[i_entry_index] <= i_entry_value;
        end
    end

    // Stage 1: nine products, floored to FRAC_BITS fraction bits
    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        localparam int ROW = (gr == 2) ? 3 : gr;
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            logic signed [2*DATA_W-1:0] w_prod;
            logic signed [2*DATA_W-1:0] w_flr;
            assign w_prod = w_pt[gc] * $signed(r_matrix[ROW*4+gc]);
            assign w_flr  = w_prod >>> FRAC_BITS;
            always_ff @(posedge i_clk) begin
                r_prod[gr*3+gc] <= w_flr[PROD_W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            r_trans[gr] <= $signed(r_matrix[ROW*4+3]);
        end
        // Stage 2: exact row sum
        always_ff @(posedge i_clk) begin
            r_clip[gr] <= CLIP_W'(r_trans[gr]) + CLIP_W'(r_prod[gr*3])
                        + CLIP_W'(r_prod[gr*3+1]) + CLIP_W'(r_prod[gr*3+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_take && i_req_type == REQ_PROJECT;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_clip[0];
    assign o_cy    = r_clip[1];
    assign o_cw    = r_clip[2];
    assign o_busy  = {1'b0, r_v1} + {1'b0, r_v2};
endmodule

@@ hw/rtl/pwsc_queue.sv @@
// ----------------------------------------------------------------------------
// pwsc_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perspective_world_to_screen_core_macros.svh"

module pwsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pwsc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= next_ptr(r_wr);
            if (i_pop)  r_rd <= next_ptr(r_rd);
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    `PWSC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count < CNT_W'(DEPTH), "queue overflow")
    `PWSC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue underflow")
    `PWSC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count out of range")
endmodule

@@ hw/rtl/pwsc_back.sv @@
// ----------------------------------------------------------------------------
// pwsc_back
// Visibility test, viewport mapping and pipelined division with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwsc_back #(
    parameter int FRAC_BITS = pwsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_take,
    input  logic signed [66-FRAC_BITS-1:0]      i_cx,
    input  logic signed [66-FRAC_BITS-1:0]      i_cy,
    input  logic signed [66-FRAC_BITS-1:0]      i_cw,
    input  logic [pwsc_pkg::SIZE_W-1:0]         i_width,
    input  logic [pwsc_pkg::SIZE_W-1:0]         i_height,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic                                o_visible,
    output logic signed [pwsc_pkg::DATA_W-1:0]  o_screen_x,
    output logic signed [pwsc_pkg::DATA_W-1:0]  o_screen_y
);
    import pwsc_pkg::*;

    localparam int CLIP_W     = 66 - FRAC_BITS;
    localparam int VIS_THRESH = ((1 << FRAC_BITS) + 5) / 10;
    localparam int MAG_W      = CLIP_W + 1;
    localparam int DW         = CLIP_W;
    localparam int RW         = DW + 1;
    localparam int PW         = MAG_W + SIZE_W;
    localparam int NW         = PW + FRAC_BITS;
    localparam int HW         = NW - QUOT_W;
    localparam int CMP_W      = (HW > DW) ? HW : DW;

    logic adv;
    logic r_out_v;

    // Stage A: visibility, numerators, divisor
    logic                 r_av, r_avis;
    logic [DW-1:0]        r_ad;
    logic                 r_aneg [2];
    logic [MAG_W-1:0]     r_amag [2];
    // Stage B: scale by display size
    logic                 r_bv, r_bvis;
    logic [DW-1:0]        r_bd;
    logic                 r_bneg [2];
    logic [PW-1:0]        r_bp [2];
    // Divider chain, index 0 holds the overflow check
    logic                 r_dv   [QUOT_W+1];
    logic                 r_dvis [QUOT_W+1];
    logic [DW-1:0]        r_dd   [QUOT_W+1];

    logic signed [MAG_W-1:0] w_num [2];
    logic [DATA_W-1:0]       w_res [2];

    assign adv    = !r_out_v || i_pop;
    assign o_take = adv && i_valid;

    assign w_num[0] = MAG_W'(i_cx) + MAG_W'(i_cw);
    assign w_num[1] = MAG_W'(i_cw) - MAG_W'(i_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            for (int k = 0; k <= QUOT_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_av <= i_valid;
            r_bv <= r_av;
            r_dv[0] <= r_bv;
            for (int k = 1; k <= QUOT_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_avis    <= i_cw >= $signed(CLIP_W'(VIS_THRESH));
            r_ad      <= {i_cw[DW-2:0], 1'b0};
            r_bvis    <= r_avis;
            r_bd      <= r_ad;
            r_dvis[0] <= r_bvis;
            r_dd[0]   <= r_bd;
            for (int k = 1; k <= QUOT_W; k++) begin
                r_dvis[k] <= r_dvis[k-1];
                r_dd[k]   <= r_dd[k-1];
            end
        end
    end

    for (genvar gl = 0; gl < 2; gl++) begin : g_lane
        logic [SIZE_W-1:0] w_size;
        logic [NW-1:0]     w_n;
        logic [HW-1:0]     w_hi;
        logic              w_ovf;
        logic              r_neg [QUOT_W+1];
        logic              r_ovf [QUOT_W+1];
        logic [RW-1:0]     r_rem [QUOT_W+1];
        logic [QUOT_W-1:0] r_lo  [QUOT_W+1];
        logic [QUOT_W-1:0] r_q   [QUOT_W+1];
        logic [QUOT_W-1:0] w_qs;

        assign w_size = (gl == 0) ? i_width : i_height;
        assign w_n    = {r_bp[gl], {FRAC_BITS{1'b0}}};
        assign w_hi   = w_n[NW-1:QUOT_W];
        assign w_ovf  = CMP_W'(w_hi) >= CMP_W'(r_bd);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_aneg[gl] <= w_num[gl][MAG_W-1];
                r_amag[gl] <= w_num[gl][MAG_W-1] ? MAG_W'(-w_num[gl]) : MAG_W'(w_num[gl]);
                r_bneg[gl] <= r_aneg[gl];
                r_bp[gl]   <= PW'(r_amag[gl]) * PW'(w_size);
                r_neg[0]   <= r_bneg[gl];
                r_ovf[0]   <= w_ovf;
                r_rem[0]   <= w_ovf ? '0 : RW'(w_hi);
                r_lo[0]    <= w_n[QUOT_W-1:0];
                r_q[0]     <= '0;
            end
        end

        // One quotient bit per stage, restoring
        for (genvar gs = 1; gs <= QUOT_W; gs++) begin : g_div
            logic [RW-1:0] w_t;
            logic          w_ge;
            assign w_t  = {r_rem[gs-1][DW-1:0], r_lo[gs-1][QUOT_W-1]};
            assign w_ge = w_t >= RW'(r_dd[gs-1]);
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_neg[gs] <= r_neg[gs-1];
                    r_ovf[gs] <= r_ovf[gs-1];
                    r_rem[gs] <= w_ge ? w_t - RW'(r_dd[gs-1]) : w_t;
                    r_lo[gs]  <= {r_lo[gs-1][QUOT_W-2:0], 1'b0};
                    r_q[gs]   <= {r_q[gs-1][QUOT_W-2:0], w_ge};
                end
            end
        end

        // Saturate to the signed 32-bit range; zero when not visible
        always_comb begin
            w_qs = r_q[QUOT_W];
            if (r_ovf[QUOT_W] || w_qs > QUOT_W'(33'h0_8000_0000)) begin
                w_qs = QUOT_W'(33'h0_8000_0000);
            end
            if (!r_dvis[QUOT_W]) begin
                w_res[gl] = '0;
            end else if (r_neg[QUOT_W]) begin
                w_res[gl] = DATA_W'(-w_qs);
            end else if (w_qs > QUOT_W'(33'h0_7FFF_FFFF)) begin
                w_res[gl] = 32'h7FFF_FFFF;
            end else begin
                w_res[gl] = w_qs[DATA_W-1:0];
            end
        end
    end

    logic              r_vis;
    logic [DATA_W-1:0] r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_dv[QUOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vis <= r_dvis[QUOT_W];
            r_sx  <= w_res[0];
            r_sy  <= w_res[1];
        end
    end

    assign o_empty    = !r_out_v;
    assign o_visible  = r_vis;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
endmodule

@@ hw/rtl/perspective_world_to_screen_core.sv @@
// ----------------------------------------------------------------------------
// perspective_world_to_screen_core
// World-to-screen projection through a stored 4x4 view matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: push an item while full is low. An item of
//   kind write stores one matrix entry and gives no result; an item of kind
//   project gives one result (visible, screen_x, screen_y).
//   Result side is a queue: the oldest result sits on the ports while empty
//   is low; pop takes it.
//   Configuration: display width and height through the cfg write channel,
//   always ready; write only while the core is idle.
//   Throughput: one item per cycle, sustained while full stays low.
//   Pipeline: an item passes two multiply/sum stages in the front, the
//   queue, then the mapping stages and the 33-stage one-bit-per-stage
//   divider in the back.
//   Reset: matrix cleared to zero, display size 1920 x 1080, queues empty.
//   Stall: when pop stays low the back pipeline holds; the front keeps
//   feeding the middle queue until it is reserved full, then full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_world_to_screen_core #(
    parameter int FRAC_BITS = pwsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_req_type,
    input  logic [pwsc_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_entry_value,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_x,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_y,
    input  logic signed [pwsc_pkg::DATA_W-1:0]  i_point_z,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_visible,
    output logic signed [pwsc_pkg::DATA_W-1:0]  o_screen_x,
    output logic signed [pwsc_pkg::DATA_W-1:0]  o_screen_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [pwsc_pkg::SIZE_W-1:0]         i_cfg_data
);
    import pwsc_pkg::*;

    localparam int CLIP_W = 66 - FRAC_BITS;
    localparam int QW     = 3 * CLIP_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    logic [SIZE_W-1:0]        r_width, r_height;
    logic                     take_in;
    logic                     f_valid;
    logic [1:0]               f_busy;
    logic signed [CLIP_W-1:0] f_cx, f_cy, f_cw;
    logic [QW-1:0]            q_out;
    logic [CNT_W-1:0]         q_count;
    logic                     b_take;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Hold full while the queue plus items in the front could fill it
    assign full    = (SUM_W'(q_count) + SUM_W'(f_busy)) >= SUM_W'(QUEUE_DEPTH);
    assign take_in = push && !full;

    pwsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take_in),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_valid       (f_valid),
        .o_cx          (f_cx),
        .o_cy          (f_cy),
        .o_cw          (f_cw),
        .o_busy        (f_busy)
    );

    pwsc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_cx, f_cy, f_cw}),
        .i_pop   (b_take),
        .o_data  (q_out),
        .o_count (q_count)
    );

    pwsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_count != '0),
        .o_take     (b_take),
        .i_cx       ($signed(q_out[3*CLIP_W-1:2*CLIP_W])),
        .i_cy       ($signed(q_out[2*CLIP_W-1:CLIP_W])),
        .i_cw       ($signed(q_out[CLIP_W-1:0])),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_visible  (o_visible),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );
endmodule

@@ tb/sv/perspective_world_to_screen_core_tb.sv @@
// ----------------------------------------------------------------------------
// perspective_world_to_screen_core_tb
// Self-checking bench for the world-to-screen projection core: a directed
// table of matrix writes and projections, then random matrices and points
// under several display sizes, with random idling on both queue sides and
// one long hold on the result side. Every result is compared field by field
// against a hand-read value or an in-bench projection model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_world_to_screen_core_tb;
    import pwsc_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int DRAIN_WAIT = 80;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam longint VIS_MIN = ((longint'(1) << FRAC) + 5) / 10;

    typedef struct packed {
        logic              req;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [DATA_W-1:0] pz;
    } cmd_t;

    typedef struct packed {
        logic              vis;
        logic [DATA_W-1:0] sx;
        logic [DATA_W-1:0] sy;
    } pixel_t;

    // Directed rows: the item, then a flag and the hand-read result.
    typedef struct packed {
        cmd_t   cmd;
        logic   typed;
        pixel_t res;
    } dir_row_t;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] MIDX = 32'h03C0_0000;   // 960 px
    localparam logic [31:0] MIDY = 32'h021C_0000;   // 540 px
    localparam int N_DIR = 23;

    localparam dir_row_t DIRECTED [N_DIR] = '{
        // zero matrix after reset: clip w is 0, never visible
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, 32'd0}},
        '{'{REQ_PROJECT, 4'd0, 32'd0, QMAX, QMIN, QMAX}, 1'b1, '{1'b0, 32'd0, 32'd0}},
        // identity on x, y and w
        '{'{REQ_WRITE, 4'd0, ONE, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd5, ONE, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd15, ONE, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        // origin lands on screen center
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{1'b1, MIDX, MIDY}},
        // far right, far down, far up: saturation both ways
        '{'{REQ_PROJECT, 4'd0, 32'd0, QMAX, 32'd0, 32'd0}, 1'b1, '{1'b1, QMAX, MIDY}},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, QMIN, 32'd0}, 1'b1, '{1'b1, MIDX, QMAX}},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, QMAX, 32'd0}, 1'b1, '{1'b1, MIDX, QMIN}},
        // w just under the visibility threshold, then exactly on it
        '{'{REQ_WRITE, 4'd15, 32'd6553, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, 32'd0}},
        '{'{REQ_WRITE, 4'd15, 32'd6554, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        // extreme entries and points
        '{'{REQ_WRITE, 4'd14, QMIN, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'd0, 32'd0, QMIN}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd3, QMAX, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd7, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000},
            1'b0, '0},
        '{'{REQ_WRITE, 4'd12, 32'h0000_4000, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd13, 32'hFFFF_C000, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, QMAX, QMIN, QMAX}, 1'b0, '0},
        '{'{REQ_WRITE, 4'd1, 32'h0002_0000, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
        '{'{REQ_PROJECT, 4'd0, 32'd0, ONE, ONE, ONE}, 1'b0, '0}
    };

    // ---------------------------------------------------------------- signals
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic              i_req_type = REQ_WRITE;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic [DATA_W-1:0] i_entry_value = '0;
    logic [DATA_W-1:0] i_point_x = '0;
    logic [DATA_W-1:0] i_point_y = '0;
    logic [DATA_W-1:0] i_point_z = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_visible;
    logic [DATA_W-1:0] o_screen_x;
    logic [DATA_W-1:0] o_screen_y;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = REG_WIDTH;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    perspective_world_to_screen_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .empty         (empty),
        .pop           (pop),
        .o_visible     (o_visible),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------- projection model
    logic signed [DATA_W-1:0] view_mat [N_ENTRY];
    logic [SIZE_W-1:0]        scr_w = WIDTH_RST;
    logic [SIZE_W-1:0]        scr_h = HEIGHT_RST;
    pixel_t                   pixel_q [$];

    int errors     = 0;
    int n_pushed   = 0;
    int n_popped   = 0;
    int n_visible  = 0;
    int cycles     = 0;
    int send_idle  = 22;
    int recv_idle  = 22;
    bit hold_req   = 1'b0;

    // Clip row: translation plus three products, each floored to FRAC bits.
    function automatic longint clip_row(int row, longint px, longint py, longint pz);
        longint acc;
        acc = longint'(view_mat[row*4+3]);
        acc += (px * longint'(view_mat[row*4+0])) >>> FRAC;
        acc += (py * longint'(view_mat[row*4+1])) >>> FRAC;
        acc += (pz * longint'(view_mat[row*4+2])) >>> FRAC;
        return acc;
    endfunction

    // size * num * 2^FRAC / (2w), truncated toward zero, saturated to 32 bits.
    function automatic logic [DATA_W-1:0] to_pixel(logic [SIZE_W-1:0] size,
                                                   longint num, longint w);
        logic [127:0] mag;
        logic [127:0] quo;
        logic         neg;
        neg = num < 0;
        mag = neg ? 128'(-num) : 128'(num);
        mag = (mag * size) << FRAC;
        quo = mag / (128'(w) * 2);
        if (quo > 128'h8000_0000) quo = 128'h8000_0000;
        if (neg) return -quo[31:0];
        if (quo > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    // Advance the model by one accepted item; hand back whether it projects.
    function automatic bit project_item(cmd_t c, output pixel_t r);
        longint cx, cy, cw;
        r = '0;
        if (c.req == REQ_WRITE) begin
            view_mat[c.idx] = c.val;
            return 1'b0;
        end
        cx = clip_row(0, longint'($signed(c.px)), longint'($signed(c.py)),
                      longint'($signed(c.pz)));
        cy = clip_row(1, longint'($signed(c.px)), longint'($signed(c.py)),
                      longint'($signed(c.pz)));
        cw = clip_row(3, longint'($signed(c.px)), longint'($signed(c.py)),
                      longint'($signed(c.pz)));
        if (cw >= VIS_MIN) begin
            r.vis = 1'b1;
            r.sx  = to_pixel(scr_w, cx + cw, cw);
            r.sy  = to_pixel(scr_h, cw - cy, cw);
        end
        return 1'b1;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    // ------------------------------------------------------------- input side
    // Offer one item, idling at random first; hold it until it is accepted.
    task automatic offer(cmd_t c, logic typed, pixel_t hand);
        pixel_t p;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_req_type    <= c.req;
        i_entry_index <= c.idx;
        i_entry_value <= c.val;
        i_point_x     <= c.px;
        i_point_y     <= c.py;
        i_point_z     <= c.pz;
        do @(posedge i_clk); while (full);
        n_pushed++;
        if (project_item(c, p))
            pixel_q.push_back(typed ? hand : p);
    endtask

    // Drop push, wait for every result, then let the write-only tail settle.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic reg_sel, logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (reg_sel == REG_WIDTH) scr_w = data;
        else scr_h = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Q16.16 value: mostly modest magnitudes, some full range, some corners.
    function automatic logic [31:0] rand_fix();
        int pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = $urandom_range(32'h0040_0000);
            return $urandom_range(1) ? -v : v;
        end
        if (pick < 80) return $urandom;
        case ($urandom_range(4))
            0: return QMAX;
            1: return QMIN;
            2: return ONE;
            3: return -ONE;
            default: return 32'd0;
        endcase
    endfunction

    // One phase: load a full random matrix with a mostly positive w row, then mix
    // projections with the odd entry rewrite.
    task automatic random_phase(int n_items);
        cmd_t c;
        for (int k = 0; k < N_ENTRY; k++) begin
            c = '0;
            c.req = REQ_WRITE;
            c.idx = IDX_W'(k);
            c.val = rand_fix();
            // keep w mostly positive so most points survive the clip test
            if (k >= 12 && $urandom_range(3) != 0) c.val = {1'b0, c.val[30:0]} >> 6;
            if (k == 15 && $urandom_range(3) != 0) c.val = $urandom_range(32'h0100_0000, ONE);
            offer(c, 1'b0, '0);
        end
        for (int k = 0; k < n_items - N_ENTRY; k++) begin
            c.req = ($urandom_range(99) < 15) ? REQ_WRITE : REQ_PROJECT;
            c.idx = IDX_W'($urandom_range(N_ENTRY - 1));
            c.val = rand_fix();
            c.px  = rand_fix();
            c.py  = rand_fix();
            c.pz  = rand_fix();
            if (c.req == REQ_WRITE && c.idx == 4'd15 && c.val[31])
                c.val = ~c.val;
            offer(c, 1'b0, '0);
        end
        drain();
    endtask

    // ------------------------------------------------------------ result side
    always @(posedge i_clk) begin : result_side
        int hold_left;
        pixel_t want;
        if (pop && !empty) begin
            n_popped++;
            if (pixel_q.size() == 0) begin
                report("result with nothing expected", 32'd0, 32'd1);
            end else begin
                want = pixel_q.pop_front();
                if (o_visible !== want.vis) report("visible", 32'(want.vis), 32'(o_visible));
                if (o_screen_x !== want.sx) report("screen_x", want.sx, o_screen_x);
                if (o_screen_y !== want.sy) report("screen_y", want.sy, o_screen_y);
                if (want.vis) n_visible++;
            end
        end
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // -------------------------------------------------------------- sequence
    initial begin
        for (int k = 0; k < N_ENTRY; k++) view_mat[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset display size
        for (int r = 0; r < N_DIR; r++)
            offer(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].res);
        drain();

        // reset size, with the result side held long enough to fill the core
        hold_req = 1'b1;
        random_phase(150);

        cfg_write(REG_WIDTH, 14'd1);
        cfg_write(REG_HEIGHT, 14'd1);
        random_phase(150);

        cfg_write(REG_WIDTH, 14'd8192);
        cfg_write(REG_HEIGHT, 14'd8192);
        send_idle = 0;
        recv_idle = 0;
        random_phase(150);          // back-to-back on both sides
        send_idle = 22;
        recv_idle = 22;

        cfg_write(REG_WIDTH, 14'h3FFF);
        cfg_write(REG_HEIGHT, 14'h3FFF);
        random_phase(150);

        cfg_write(REG_WIDTH, 14'd0);
        cfg_write(REG_HEIGHT, 14'd0);
        random_phase(120);

        cfg_write(REG_WIDTH, 14'd640);
        cfg_write(REG_HEIGHT, 14'd8191);
        random_phase(150);

        cfg_write(REG_WIDTH, SIZE_W'($urandom_range(1, 8192)));
        cfg_write(REG_HEIGHT, SIZE_W'($urandom_range(1, 8192)));
        random_phase(150);

        $display("Covered %0d items pushed, %0d results popped (%0d visible),",
                 n_pushed, n_popped, n_visible);
        $display("display sizes from 0 to 16383 and one long result-side hold.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
